[src/tlpt_pkg.sv]
package tlpt_pkg;

    // Address split
    localparam int unsigned IDX_W      = 10;
    localparam int unsigned OFS_W      = 12;
    localparam int unsigned DIR_LSB    = 22;
    localparam int unsigned TBL_LSB    = 12;
    localparam int unsigned DIR_DEPTH  = 1024;
    localparam int unsigned TBL_DEPTH  = 1024;

    // Default number of page table slots
    localparam int unsigned TABLE_SLOTS_DEF = 8;

    // Request opcodes
    typedef logic [1:0] t_op;
    localparam t_op OP_MAP     = 2'd0;
    localparam t_op OP_UNMAP   = 2'd1;
    localparam t_op OP_RESOLVE = 2'd2;
    localparam t_op OP_PROTECT = 2'd3;

    // Table write source select
    typedef logic [1:0] t_twr;
    localparam t_twr TW_NONE = 2'd0;
    localparam t_twr TW_MAP  = 2'd1;
    localparam t_twr TW_ZERO = 2'd2;
    localparam t_twr TW_PROT = 2'd3;

    // Controller to datapath commands
    typedef struct packed {
        logic latch;      // capture request fields
        logic dir_rd;     // read directory at incoming address
        logic dir_alloc;  // write new directory entry, bump slot counter
        logic init_wr;    // directory clearing pass write
        logic cnt_clr;    // clear sweep counter
        logic cnt_inc;    // advance sweep counter
        logic sweep_wr;   // zero-fill write of newly allocated table
        logic tbl_rd;     // read table entry
        t_twr tbl_wr;     // single table entry write
        logic rsp;        // present result
        logic rsp_fail;   // result status is failure
        logic rsp_xlat;   // result carries translated address
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        t_op  op;
        logic dir_present;
        logic slot_free;
        logic ent_present;
        logic cnt_last;
    } t_sts;

endpackage

[src/tlpt_ctrl.sv]
module tlpt_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    input  tlpt_pkg::t_sts i_sts,
    output tlpt_pkg::t_cmd o_cmd,
    output logic           busy
);

    localparam logic [2:0] ST_INIT  = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_DIR   = 3'd2;
    localparam logic [2:0] ST_SWEEP = 3'd3;
    localparam logic [2:0] ST_TBL   = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    assign busy = (r_state != ST_IDLE);

    // Next state and command decode
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_INIT: begin
                o_cmd.init_wr = 1'b1;
                o_cmd.cnt_inc = 1'b1;
                if (i_sts.cnt_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (start) begin
                    o_cmd.latch  = 1'b1;
                    o_cmd.dir_rd = 1'b1;
                    n_state      = ST_DIR;
                end
            end
            ST_DIR: begin
                if (i_sts.dir_present) begin
                    if (i_sts.op == tlpt_pkg::OP_MAP) begin
                        o_cmd.tbl_wr = tlpt_pkg::TW_MAP;
                        o_cmd.rsp    = 1'b1;
                        n_state      = ST_IDLE;
                    end else if (i_sts.op == tlpt_pkg::OP_UNMAP) begin
                        o_cmd.tbl_wr = tlpt_pkg::TW_ZERO;
                        o_cmd.rsp    = 1'b1;
                        n_state      = ST_IDLE;
                    end else begin
                        o_cmd.tbl_rd = 1'b1;
                        n_state      = ST_TBL;
                    end
                end else if (i_sts.op == tlpt_pkg::OP_MAP && i_sts.slot_free) begin
                    o_cmd.dir_alloc = 1'b1;
                    o_cmd.cnt_clr   = 1'b1;
                    n_state         = ST_SWEEP;
                end else begin
                    o_cmd.rsp      = 1'b1;
                    o_cmd.rsp_fail = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            ST_SWEEP: begin
                // zero the new table; the mapped entry gets its word on the way
                o_cmd.sweep_wr = 1'b1;
                o_cmd.cnt_inc  = 1'b1;
                if (i_sts.cnt_last) begin
                    o_cmd.rsp = 1'b1;
                    n_state   = ST_IDLE;
                end
            end
            ST_TBL: begin
                o_cmd.rsp = 1'b1;
                n_state   = ST_IDLE;
                if (i_sts.ent_present) begin
                    if (i_sts.op == tlpt_pkg::OP_PROTECT) begin
                        o_cmd.tbl_wr = tlpt_pkg::TW_PROT;
                    end
                    o_cmd.rsp_xlat = (i_sts.op inside {tlpt_pkg::OP_RESOLVE});
                end else begin
                    o_cmd.rsp_fail = 1'b1;
                end
            end
            default: begin
                n_state = ST_INIT;
            end
        endcase
    end

endmodule

[src/tlpt_dp.sv]
module tlpt_dp #(
    parameter int unsigned TABLE_SLOTS = tlpt_pkg::TABLE_SLOTS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  tlpt_pkg::t_cmd i_cmd,
    output tlpt_pkg::t_sts o_sts,
    input  logic [1:0]     i_opcode,
    input  logic [31:0]    i_virt_addr,
    input  logic [31:0]    i_phys_addr,
    input  logic [11:0]    i_page_flags,
    output logic           o_valid,
    output logic           o_status,
    output logic [31:0]    o_phys_result
);

    localparam int unsigned SLOT_W  = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam int unsigned CNT_W   = $clog2(TABLE_SLOTS + 1);
    localparam int unsigned DEPTH   = TABLE_SLOTS * tlpt_pkg::TBL_DEPTH;
    localparam int unsigned ADDR_W  = $clog2(DEPTH);
    localparam int unsigned IDX_W   = tlpt_pkg::IDX_W;
    localparam int unsigned FRM_W   = 32 - tlpt_pkg::OFS_W;

    // Latched request
    tlpt_pkg::t_op      r_op;
    logic [IDX_W-1:0]   r_di;
    logic [IDX_W-1:0]   r_ti;
    logic [11:0]        r_ofs;
    logic [FRM_W-1:0]   r_frame;
    logic [11:0]        r_fl;

    // Memories and read registers
    logic [SLOT_W:0]    r_dir_mem [tlpt_pkg::DIR_DEPTH];
    logic [31:0]        r_tbl_mem [DEPTH];
    logic [SLOT_W:0]    r_dir_q;
    logic [31:0]        r_tbl_q;

    // Control state
    logic [CNT_W-1:0]   r_next_slot;
    logic [SLOT_W-1:0]  r_slot;
    logic [IDX_W-1:0]   r_cnt;

    logic [31:0]        w_map_word;
    logic [SLOT_W-1:0]  w_slot;
    logic [IDX_W-1:0]   w_ti;
    logic [ADDR_W-1:0]  w_tbl_addr;
    logic [31:0]        w_tbl_wdata;
    logic               w_tbl_we;
    logic [IDX_W-1:0]   w_dir_addr;
    logic [SLOT_W:0]    w_dir_wdata;

    // Request capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_op    <= i_opcode;
            r_di    <= i_virt_addr[31:tlpt_pkg::DIR_LSB];
            r_ti    <= i_virt_addr[tlpt_pkg::DIR_LSB-1:tlpt_pkg::TBL_LSB];
            r_ofs   <= i_virt_addr[tlpt_pkg::OFS_W-1:0];
            r_frame <= i_phys_addr[31:tlpt_pkg::OFS_W];
            r_fl    <= i_page_flags;
        end
    end

    // Sweep counter and slot allocator
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= '0;
            r_next_slot <= '0;
        end else begin
            if (i_cmd.cnt_clr) begin
                r_cnt <= '0;
            end else if (i_cmd.cnt_inc) begin
                r_cnt <= r_cnt + 1'b1;
            end
            if (i_cmd.dir_alloc) begin
                r_next_slot <= r_next_slot + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.dir_alloc) begin
            r_slot <= r_next_slot[SLOT_W-1:0];
        end
    end

    // Page directory: one write port, registered read
    assign w_dir_addr  = i_cmd.init_wr ? r_cnt : r_di;
    assign w_dir_wdata = i_cmd.init_wr ? '0 : {1'b1, r_next_slot[SLOT_W-1:0]};

    always_ff @(posedge i_clk) begin
        if (i_cmd.init_wr || i_cmd.dir_alloc) begin
            r_dir_mem[w_dir_addr] <= w_dir_wdata;
        end
        if (i_cmd.dir_rd) begin
            r_dir_q <= r_dir_mem[i_virt_addr[31:tlpt_pkg::DIR_LSB]];
        end
    end

    // Page table store: one write port, registered read
    assign w_map_word = {r_frame, r_fl | 12'h001};
    assign w_slot     = i_cmd.sweep_wr ? r_slot : r_dir_q[SLOT_W-1:0];
    assign w_ti       = i_cmd.sweep_wr ? r_cnt : r_ti;
    assign w_tbl_addr = ADDR_W'({w_slot, w_ti});
    assign w_tbl_we   = i_cmd.sweep_wr || (i_cmd.tbl_wr != tlpt_pkg::TW_NONE);

    always_comb begin
        if (i_cmd.sweep_wr) begin
            w_tbl_wdata = (r_cnt == r_ti) ? w_map_word : '0;
        end else begin
            case (i_cmd.tbl_wr)
                tlpt_pkg::TW_MAP:  w_tbl_wdata = w_map_word;
                tlpt_pkg::TW_PROT: w_tbl_wdata = {r_tbl_q[31:tlpt_pkg::OFS_W],
                                                  r_fl | 12'h001};
                default:           w_tbl_wdata = '0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_tbl_we) begin
            r_tbl_mem[w_tbl_addr] <= w_tbl_wdata;
        end
        if (i_cmd.tbl_rd) begin
            r_tbl_q <= r_tbl_mem[w_tbl_addr];
        end
    end

    // Status back to the controller
    assign o_sts.op          = r_op;
    assign o_sts.dir_present = r_dir_q[SLOT_W];
    assign o_sts.slot_free   = (r_next_slot < CNT_W'(TABLE_SLOTS));
    assign o_sts.ent_present = r_tbl_q[0];
    assign o_sts.cnt_last    = (r_cnt == {IDX_W{1'b1}});

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= i_cmd.rsp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rsp) begin
            o_status      <= i_cmd.rsp_fail;
            o_phys_result <= i_cmd.rsp_xlat ? {r_tbl_q[31:tlpt_pkg::OFS_W], r_ofs} : '0;
        end
    end

endmodule

[src/two_level_page_table_manager.sv]
// Two-level page table manager. A request is taken when start is high and
// busy is low; exactly one result follows, shown for a single cycle with
// o_valid high, and the receiver cannot stall it. The result strobe comes the
// cycle after the last processing cycle and busy is already low then. Map or
// unmap under a present directory entry does a directory read, then a table
// write; resolve and protect do a directory read, a table read, then
// write-back or result. A map that allocates a new table zero-fills it
// through the single table write port, one entry per cycle. Requests failing
// at the directory end after the directory read. After reset, busy stays
// high while the directory is cleared.
module two_level_page_table_manager #(
    parameter int unsigned TABLE_SLOTS = tlpt_pkg::TABLE_SLOTS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_opcode,
    input  logic [31:0] i_virt_addr,
    input  logic [31:0] i_phys_addr,
    input  logic [11:0] i_page_flags,
    output logic        o_valid,
    output logic        o_status,
    output logic [31:0] o_phys_result
);

    tlpt_pkg::t_cmd w_cmd;
    tlpt_pkg::t_sts w_sts;

    // Controller
    tlpt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd),
        .busy    (busy)
    );

    // Datapath with directory and table memories
    tlpt_dp #(
        .TABLE_SLOTS (TABLE_SLOTS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .i_opcode      (i_opcode),
        .i_virt_addr   (i_virt_addr),
        .i_phys_addr   (i_phys_addr),
        .i_page_flags  (i_page_flags),
        .o_valid       (o_valid),
        .o_status      (o_status),
        .o_phys_result (o_phys_result)
    );

    // A result never overlaps an open transaction
    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result strobe while busy");

    // An accepted transaction holds off the next one
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transaction did not raise busy");

    // One strobe per transaction
    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("back-to-back result strobes");

    // Failures carry a zero address
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status) |-> (o_phys_result == 32'd0))
        else $error("failed transaction with nonzero address");

endmodule
